// ===== hw/rtl/bsm_pkg.sv =====
// Shared types and codes for the bank-switched memory map.
`timescale 1ns / 1ps

package bsm_pkg;

  // Item action codes
  localparam logic [2:0] ACT_READ        = 3'd0;
  localparam logic [2:0] ACT_WRITE       = 3'd1;
  localparam logic [2:0] ACT_LOAD_BASIC  = 3'd2;
  localparam logic [2:0] ACT_LOAD_KERNEL = 3'd3;
  localparam logic [2:0] ACT_LOAD_GLYPH  = 3'd4;

  // Result source codes
  localparam logic [2:0] SRC_RAM    = 3'd0;
  localparam logic [2:0] SRC_BASIC  = 3'd1;
  localparam logic [2:0] SRC_KERNEL = 3'd2;
  localparam logic [2:0] SRC_GLYPH  = 3'd3;
  localparam logic [2:0] SRC_IO     = 3'd4;
  localparam logic [2:0] SRC_PORT   = 3'd5;

  // Processor port bus addresses
  localparam logic [15:0] ADDR_DIR  = 16'h0000;
  localparam logic [15:0] ADDR_PORT = 16'h0001;

  // Reset values of the port registers
  localparam logic [7:0] DIR_RESET  = 8'h2F;
  localparam logic [7:0] PORT_RESET = 8'h37;
  localparam logic [7:0] IO_FLOAT   = 8'hFF;

  // Store address widths
  localparam int unsigned RAM_AW   = 16;
  localparam int unsigned BASIC_AW = 13;
  localparam int unsigned KERNEL_AW = 13;
  localparam int unsigned GLYPH_AW = 12;

  // Where the read byte of an item comes from
  typedef enum logic [2:0] {
    RSEL_IMM,
    RSEL_RAM,
    RSEL_BASIC,
    RSEL_KERNEL,
    RSEL_GLYPH
  } rsel_t;

  // Decoded access, from the decoder to the top level
  typedef struct packed {
    logic       ram_we;
    logic       ram_re;
    logic       basic_we;
    logic       basic_re;
    logic       kernel_we;
    logic       kernel_re;
    logic       glyph_we;
    logic       glyph_re;
    logic       dir_we;
    logic       port_we;
    rsel_t      rsel;
    logic [7:0] rd_imm;
    logic [2:0] src;
    logic       sel;
    logic       wr;
  } dec_t;

endpackage

// ===== hw/rtl/bank_switched_memory_map_unit.sv =====
// Top level of the bank-switched 64K memory map with processor port.
`timescale 1ns / 1ps
// Path: stage 1 holds the item while the store reads, then the output
//   register presents it. Throughput: 1 item per cycle unless out_stall
//   blocks stage 1; every access is at most one read or one write on a
//   single-port store (RAM, basic, kernel or glyph), so nothing serializes.
// Reset (rst_n, synchronous, active low): port direction 0x2F, port data
//   0x37, io_attached 0, pipeline empty. Stores are not cleared; an entry
//   never written reads as whatever the RAM holds.
module bank_switched_memory_map_unit
  import bsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_io_read_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [2:0]  out_source,
  output logic        out_io_select,
  output logic        out_io_write,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------
  // Configuration: one register, io_attached, at byte address 0.
  // ---------------------------------------------------------------------
  logic io_att_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  // paddr is ignored; every address reads register 0
  assign prdata = {31'd0, io_att_r} | {30'd0, paddr & 2'b00};

  // ---------------------------------------------------------------------
  // Processor port registers
  // ---------------------------------------------------------------------
  logic [7:0] dir_r;
  logic [7:0] port_r;

  // ---------------------------------------------------------------------
  // Pipeline: stage 0 decodes and issues the store access at accept, stage 1
  // holds the decoded result while the store's read data is valid, output
  // register presents the result. Stage 1 acts as skid: the store data
  // holds because the stores read only on accept.
  // ---------------------------------------------------------------------
  dec_t       dec;
  logic       in_acc;
  logic       s1_move;

  logic       s1_valid_r;
  rsel_t      s1_rsel_r;
  logic [7:0] s1_rd_imm_r;
  logic [2:0] s1_src_r;
  logic       s1_sel_r;
  logic       s1_wr_r;

  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic [2:0] out_src_r;
  logic       out_sel_r;
  logic       out_wr_r;

  logic [7:0] ram_q;
  logic [7:0] basic_q;
  logic [7:0] kernel_q;
  logic [7:0] glyph_q;
  logic [7:0] s1_rd;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  bsm_decode u_decode (
    .action       (in_action),
    .address      (in_address),
    .io_read_data (in_io_read_data),
    .dir          (dir_r),
    .port         (port_r),
    .io_attached  (io_att_r),
    .dec          (dec)
  );

  // Stores: all indexed by the low address bits, for bus access and loads
  bsm_ram #(.AW(RAM_AW), .DW(8)) u_ram (
    .clk   (clk),
    .we    (in_acc && dec.ram_we),
    .re    (in_acc && dec.ram_re),
    .addr  (in_address[RAM_AW-1:0]),
    .wdata (in_write_data),
    .rdata (ram_q)
  );

  bsm_ram #(.AW(BASIC_AW), .DW(8)) u_basic (
    .clk   (clk),
    .we    (in_acc && dec.basic_we),
    .re    (in_acc && dec.basic_re),
    .addr  (in_address[BASIC_AW-1:0]),
    .wdata (in_write_data),
    .rdata (basic_q)
  );

  bsm_ram #(.AW(KERNEL_AW), .DW(8)) u_kernel (
    .clk   (clk),
    .we    (in_acc && dec.kernel_we),
    .re    (in_acc && dec.kernel_re),
    .addr  (in_address[KERNEL_AW-1:0]),
    .wdata (in_write_data),
    .rdata (kernel_q)
  );

  bsm_ram #(.AW(GLYPH_AW), .DW(8)) u_glyph (
    .clk   (clk),
    .we    (in_acc && dec.glyph_we),
    .re    (in_acc && dec.glyph_re),
    .addr  (in_address[GLYPH_AW-1:0]),
    .wdata (in_write_data),
    .rdata (glyph_q)
  );

  // pick the byte for the stage 1 item
  always_comb begin
    case (s1_rsel_r)
      RSEL_RAM:    s1_rd = ram_q;
      RSEL_BASIC:  s1_rd = basic_q;
      RSEL_KERNEL: s1_rd = kernel_q;
      RSEL_GLYPH:  s1_rd = glyph_q;
      default:     s1_rd = s1_rd_imm_r;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_att_r    <= 1'b0;
      dir_r       <= DIR_RESET;
      port_r      <= PORT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        io_att_r <= pwdata[0];
      end
      // port writes take effect for the very next item
      if (in_acc && dec.dir_we) begin
        dir_r <= in_write_data;
      end
      if (in_acc && dec.port_we) begin
        port_r <= in_write_data;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rsel_r   <= dec.rsel;
      s1_rd_imm_r <= dec.rd_imm;
      s1_src_r    <= dec.src;
      s1_sel_r    <= dec.sel;
      s1_wr_r     <= dec.wr;
    end
    if (s1_move) begin
      out_rd_r  <= s1_rd;
      out_src_r <= s1_src_r;
      out_sel_r <= s1_sel_r;
      out_wr_r  <= s1_wr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_source    = out_src_r;
  assign out_io_select = out_sel_r;
  assign out_io_write  = out_wr_r;

`ifndef SYNTH
  // a blocked stage 1 item keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_src_r) && $stable(s1_rsel_r))
    else $error("stage 1 item lost while blocked");

  // a device write is always a device select
  a_io_wr_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_io_write |-> out_io_select && out_source == SRC_IO)
    else $error("device write without select");

  // no item accepted while stage 1 cannot drain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |-> !in_acc)
    else $error("item accepted into full pipeline");

  // direction write lands for the next item
  a_dir_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && dec.dir_we |=> dir_r == $past(in_write_data))
    else $error("direction register write lost");
`endif

endmodule

// ===== hw/rtl/bsm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module bsm_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/bsm_decode.sv =====
// Address and bank decode of one item against the current port setting.
`timescale 1ns / 1ps

module bsm_decode
  import bsm_pkg::*;
(
  input  logic [2:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  io_read_data,
  input  logic [7:0]  dir,
  input  logic [7:0]  port,
  input  logic        io_attached,
  output dec_t        dec
);

  logic [7:0] eff;
  logic       low;
  logic       high;
  logic       charsel;
  logic       in_io;
  logic       in_basic;
  logic       in_kernel;
  logic       io_map;

  // input bits of the port read as 1
  assign eff       = (port & dir) | ~dir;
  assign low       = eff[0];
  assign high      = eff[1];
  assign charsel   = eff[2];
  assign in_io     = (address[15:12] == 4'hD);
  assign in_basic  = (address[15:13] == 3'b101);
  assign in_kernel = (address[15:13] == 3'b111);
  assign io_map    = (low | high) & charsel;

  always_comb begin
    dec = '0;
    dec.rsel = RSEL_IMM;
    dec.src  = SRC_RAM;
    unique case (action)
      ACT_READ: begin
        if (address == ADDR_DIR) begin
          dec.rd_imm = dir;
          dec.src    = SRC_PORT;
        end else if (address == ADDR_PORT) begin
          dec.rd_imm = eff;
          dec.src    = SRC_PORT;
        end else if (in_basic && low && high) begin
          dec.basic_re = 1'b1;
          dec.rsel     = RSEL_BASIC;
          dec.src      = SRC_BASIC;
        end else if (in_kernel && high) begin
          dec.kernel_re = 1'b1;
          dec.rsel      = RSEL_KERNEL;
          dec.src       = SRC_KERNEL;
        end else if (in_io && (low || high)) begin
          if (io_map) begin
            dec.src    = SRC_IO;
            dec.sel    = io_attached;
            dec.rd_imm = io_attached ? io_read_data : IO_FLOAT;
          end else begin
            dec.glyph_re = 1'b1;
            dec.rsel     = RSEL_GLYPH;
            dec.src      = SRC_GLYPH;
          end
        end else begin
          dec.ram_re = 1'b1;
          dec.rsel   = RSEL_RAM;
        end
      end
      ACT_WRITE: begin
        if (address == ADDR_DIR) begin
          dec.dir_we = 1'b1;
          dec.src    = SRC_PORT;
        end else if (address == ADDR_PORT) begin
          dec.port_we = 1'b1;
          dec.src     = SRC_PORT;
        end else if (in_io && io_map) begin
          dec.src = SRC_IO;
          dec.sel = io_attached;
          dec.wr  = io_attached;
        end else begin
          dec.ram_we = 1'b1;
        end
      end
      ACT_LOAD_BASIC: begin
        dec.basic_we = 1'b1;
        dec.src      = SRC_BASIC;
      end
      ACT_LOAD_KERNEL: begin
        dec.kernel_we = 1'b1;
        dec.src       = SRC_KERNEL;
      end
      ACT_LOAD_GLYPH: begin
        dec.glyph_we = 1'b1;
        dec.src      = SRC_GLYPH;
      end
      default: begin
        // unused action codes: all-zero result, no side effects
        dec.src = SRC_RAM;
      end
    endcase
  end

endmodule
